// ===== hw/rtl/pft_pkg.sv =====
// Shared types, constants and helpers for the periodic foot trajectory core.
// No dependencies; the top-level core and pft_cfg import this package.
`default_nettype none

package pft_pkg;

  // Time stamps are taken modulo 2^TimeBits; positions saturate to PosBits.
  localparam int TimeBits = 32;
  localparam int PosBits  = 32;

  localparam int TIME_W = (TimeBits < 32) ? TimeBits : 32;
  localparam logic [31:0] TIME_MASK =
    (TIME_W >= 32) ? 32'hFFFF_FFFF : 32'((64'd1 << TIME_W) - 64'd1);
  localparam int SAT_W = (PosBits < 32) ? PosBits : 32;

  localparam int TICK_W = 24;          // swing / stance register width
  localparam int PER_W  = TICK_W + 1;  // swing + stance, also 2 * swing
  localparam int Q_W    = 32;          // quotient width of every divider
  localparam int E_W    = TICK_W + 2;  // forward fraction numerator
  localparam int F_W    = TICK_W + 1;  // height fraction numerator
  localparam int H_W    = 33;          // whole steps multiplier
  localparam int LH_W   = 66;          // stride * whole steps
  localparam int OFF_W  = 34;          // rounded fractional offset
  localparam int SUM_W  = 67;          // start + offsets

  localparam logic [TICK_W-1:0] SWING_RST  = 24'd1000;
  localparam logic [TICK_W-1:0] STANCE_RST = 24'd1000;

  typedef enum logic [2:0] {
    REG_START_X     = 3'd0,
    REG_START_Z     = 3'd1,
    REG_STEP_LENGTH = 3'd2,
    REG_STEP_HEIGHT = 3'd3,
    REG_START_TIME  = 3'd4,
    REG_SWING_TICKS = 3'd5,
    REG_STANCE_TICKS = 3'd6,
    REG_HALF_FIRST  = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic signed [31:0] start_x;
    logic signed [31:0] start_z;
    logic signed [31:0] stride;
    logic signed [31:0] lift;
    logic [31:0]        start_time;
    logic [TICK_W-1:0]  swing_ticks;
    logic [TICK_W-1:0]  stance_ticks;
    logic               half_first_step;
  } cfg_t;

  // Clamp to the PosBits range, then to the 32-bit field.
  function automatic logic [31:0] sat_pos(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    logic signed [SUM_W-1:0] c;
    hi = $signed((SUM_W'(1) << (SAT_W - 1)) - SUM_W'(1));
    lo = -hi - SUM_W'(1);
    if (v > hi) begin
      c = hi;
    end else if (v < lo) begin
      c = lo;
    end else begin
      c = v;
    end
    return c[31:0];
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/periodic_foot_trajectory_ref_core.sv =====
// Top level of the periodic swing-foot trajectory core.
// Depends on pft_pkg, pft_cfg and pft_div.
//
//   channel   direction  handshake            payload
//   input     in         in_valid / in_ready  time_now
//   result    out        out_valid / out_ready ref_x, ref_z
//   config    in         cfg_we (no wait)     cfg_idx, cfg_wdata
//
// One item per cycle unless stalled; items pass two 32-stage divider steps
// (period split, then fractional scaling) plus five arithmetic stages.
// All stages advance together; a held result stalls the whole pipeline.
// Synchronous reset clears every valid bit and resets the config registers.

`default_nettype none

module periodic_foot_trajectory_ref_core
  import pft_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] time_now,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] ref_x,
  output logic [31:0] ref_z,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_idx,
  input  logic [31:0] cfg_wdata
);

  cfg_t cfg;
  logic en;

  pft_cfg u_cfg (
    .clk, .rst, .cfg_we, .cfg_idx, .cfg_wdata, .cfg
  );

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // Derived config; user holds it stable for items in flight, unchecked.
  logic [TICK_W-1:0] sw;
  logic [PER_W-1:0]  per;
  logic [PER_W-1:0]  sw2;
  assign sw  = (cfg.swing_ticks == '0) ? TICK_W'(1) : cfg.swing_ticks;
  assign per = {1'b0, sw} + {1'b0, cfg.stance_ticks};
  assign sw2 = {sw, 1'b0};

  // Stage A: offset from start time.
  logic        a_v;
  logic        a_pre;
  logic [31:0] a_d;
  logic [31:0] t_m;
  logic [31:0] t0_m;
  assign t_m  = time_now & TIME_MASK;
  assign t0_m = cfg.start_time & TIME_MASK;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0;
    end else if (en) begin
      a_v <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_pre <= (t_m >= t0_m);
      a_d   <= t_m - t0_m;
    end
  end

  // Whole periods and phase within the period.
  logic             p_v;
  logic [Q_W-1:0]   steps;
  logic [PER_W-1:0] tau;
  logic             p_pre;

  pft_div #(.DEN_W(PER_W), .Q_W(Q_W), .SIDE_W(1)) u_div_per (
    .clk, .rst, .en,
    .in_valid (a_v),
    .num      ({PER_W'(0), a_d}),
    .den      (per),
    .side_in  (a_pre),
    .out_valid(p_v),
    .quo      (steps),
    .rmd      (tau),
    .side_out (p_pre)
  );

  // Stage B: split offsets into whole-step count and fractional numerators
  // over the common divisor 2 * swing.
  logic           swing_ph;
  logic [H_W-1:0] h_c;
  logic [E_W-1:0] e_c;
  logic [F_W-1:0] f_c;
  logic [H_W-1:0] steps_w;
  logic [E_W-1:0] tau2;
  logic [F_W+1:0] f_full;
  logic [PER_W-1:0] sw_rest;

  assign steps_w  = {1'b0, steps};
  assign swing_ph = (tau < {1'b0, sw});
  assign tau2     = E_W'({tau, 1'b0});
  assign sw_rest  = {1'b0, sw} - tau;

  always_comb begin
    h_c = '0;
    e_c = '0;
    if (cfg.half_first_step) begin
      priority if (steps == '0 && swing_ph) begin
        e_c = E_W'(tau);
      end else if (steps == '0) begin
        e_c = E_W'(sw);
      end else if (swing_ph) begin
        h_c = steps_w - H_W'(1);
        e_c = E_W'(sw) + tau2;
      end else begin
        h_c = steps_w;
        e_c = E_W'(sw);
      end
    end else begin
      if (swing_ph) begin
        h_c = steps_w;
        e_c = tau2;
      end else begin
        h_c = steps_w + H_W'(1);
      end
    end
    // Triangle: rising before mid-swing, falling from mid-swing on.
    if (!swing_ph) begin
      f_full = '0;
    end else if (tau2 < E_W'(sw)) begin
      f_full = (F_W+2)'({tau, 2'b00});
    end else begin
      f_full = {sw_rest, 2'b00};
    end
    f_c = f_full[F_W-1:0];
  end

  logic           b_v;
  logic           b_pre;
  logic [H_W-1:0] b_h;
  logic [E_W-1:0] b_e;
  logic [F_W-1:0] b_f;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_v <= 1'b0;
    end else if (en) begin
      b_v <= p_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_pre <= p_pre;
      b_h   <= h_c;
      b_e   <= e_c;
      b_f   <= f_c;
    end
  end

  // Stage C: products.
  logic [31:0] mag_l;
  logic [31:0] mag_h;
  logic signed [LH_W-1:0] lh_c;
  logic [Q_W+PER_W:0] le_c;
  logic [Q_W+PER_W:0] hf_c;

  assign mag_l = cfg.stride[31] ? 32'(-cfg.stride) : cfg.stride;
  assign mag_h = cfg.lift[31] ? 32'(-cfg.lift) : cfg.lift;
  assign lh_c  = cfg.stride * $signed({1'b0, b_h});
  assign le_c  = (Q_W+PER_W+1)'(mag_l) * (Q_W+PER_W+1)'(b_e);
  assign hf_c  = (Q_W+PER_W+1)'(mag_h) * (Q_W+PER_W+1)'(b_f);

  logic                   c_v;
  logic                   c_pre;
  logic signed [LH_W-1:0] c_lh;
  logic [Q_W+PER_W-1:0]   c_le;
  logic [Q_W+PER_W-1:0]   c_hf;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_v <= 1'b0;
    end else if (en) begin
      c_v <= b_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_pre <= b_pre;
      c_lh  <= lh_c;
      c_le  <= le_c[Q_W+PER_W-1:0];
      c_hf  <= hf_c[Q_W+PER_W-1:0];
    end
  end

  // Fractional offsets over 2 * swing, both dividers in lockstep.
  logic             x_v;
  logic [Q_W-1:0]   qx;
  logic [PER_W-1:0] rx;
  logic [LH_W-1:0]  x_lh;
  logic             z_v;
  logic [Q_W-1:0]   qz;
  logic [PER_W-1:0] rz;
  logic             z_pre;

  pft_div #(.DEN_W(PER_W), .Q_W(Q_W), .SIDE_W(LH_W)) u_div_x (
    .clk, .rst, .en,
    .in_valid (c_v),
    .num      (c_le),
    .den      (sw2),
    .side_in  (c_lh),
    .out_valid(x_v),
    .quo      (qx),
    .rmd      (rx),
    .side_out (x_lh)
  );

  pft_div #(.DEN_W(PER_W), .Q_W(Q_W), .SIDE_W(1)) u_div_z (
    .clk, .rst, .en,
    .in_valid (c_v),
    .num      (c_hf),
    .den      (sw2),
    .side_in  (c_pre),
    .out_valid(z_v),
    .quo      (qz),
    .rmd      (rz),
    .side_out (z_pre)
  );

  // Stage D: floor rounding for negative scale factors.
  logic signed [OFF_W-1:0] ox_c;
  logic signed [OFF_W-1:0] oz_c;
  logic [OFF_W-1:0] qx_up;
  logic [OFF_W-1:0] qz_up;

  assign qx_up = OFF_W'(qx) + OFF_W'(rx != '0);
  assign qz_up = OFF_W'(qz) + OFF_W'(rz != '0);
  assign ox_c  = cfg.stride[31] ? -$signed(qx_up) : $signed(OFF_W'(qx));
  assign oz_c  = cfg.lift[31] ? -$signed(qz_up) : $signed(OFF_W'(qz));

  logic                    d_v;
  logic                    d_pre;
  logic signed [LH_W-1:0]  d_lh;
  logic signed [OFF_W-1:0] d_ox;
  logic signed [OFF_W-1:0] d_oz;

  always_ff @(posedge clk) begin
    if (rst) begin
      d_v <= 1'b0;
    end else if (en) begin
      d_v <= x_v && z_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_pre <= z_pre;
      d_lh  <= $signed(x_lh);
      d_ox  <= ox_c;
      d_oz  <= oz_c;
    end
  end

  // Stage E: add to start point, saturate, hold for the consumer.
  logic signed [SUM_W-1:0] sum_x;
  logic signed [SUM_W-1:0] sum_z;

  always_comb begin
    sum_x = SUM_W'(cfg.start_x);
    sum_z = SUM_W'(cfg.start_z);
    if (d_pre) begin
      sum_x = SUM_W'(cfg.start_x) + SUM_W'(d_lh) + SUM_W'(d_ox);
      sum_z = SUM_W'(cfg.start_z) + SUM_W'(d_oz);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= d_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ref_x <= sat_pos(sum_x);
      ref_z <= sat_pos(sum_z);
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/pft_div.sv =====
// Pipelined restoring divider, one quotient bit per register stage.
// Standalone; numerator's upper DEN_W bits must be below the divisor.
`default_nettype none

module pft_div #(
  parameter int DEN_W  = 25,
  parameter int Q_W    = 32,
  parameter int SIDE_W = 1
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  logic                   in_valid,
  input  logic [Q_W+DEN_W-1:0]   num,
  input  logic [DEN_W-1:0]       den,
  input  logic [SIDE_W-1:0]      side_in,
  output logic                   out_valid,
  output logic [Q_W-1:0]         quo,
  output logic [DEN_W-1:0]       rmd,
  output logic [SIDE_W-1:0]      side_out
);

  logic              vld  [Q_W];
  logic [DEN_W-1:0]  r_st [Q_W];
  logic [Q_W-1:0]    n_st [Q_W];
  logic [Q_W-1:0]    q_st [Q_W];
  logic [SIDE_W-1:0] s_st [Q_W];

  logic [DEN_W-1:0]  r_src [Q_W];
  logic [Q_W-1:0]    n_src [Q_W];
  logic [Q_W-1:0]    q_src [Q_W];
  logic [SIDE_W-1:0] s_src [Q_W];
  logic [DEN_W:0]    trial [Q_W];
  logic              ge    [Q_W];
  logic [DEN_W-1:0]  r_next [Q_W];

  always_comb begin
    for (int k = 0; k < Q_W; k++) begin
      if (k == 0) begin
        r_src[k] = num[Q_W+DEN_W-1:Q_W];
        n_src[k] = num[Q_W-1:0];
        q_src[k] = '0;
        s_src[k] = side_in;
      end else begin
        r_src[k] = r_st[k-1];
        n_src[k] = n_st[k-1];
        q_src[k] = q_st[k-1];
        s_src[k] = s_st[k-1];
      end
      trial[k] = {r_src[k], n_src[k][Q_W-1]};
      ge[k]    = (trial[k] >= {1'b0, den});
      r_next[k] = ge[k] ? DEN_W'(trial[k] - {1'b0, den}) : trial[k][DEN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < Q_W; k++) vld[k] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
      for (int k = 1; k < Q_W; k++) vld[k] <= vld[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < Q_W; k++) begin
        r_st[k] <= r_next[k];
        n_st[k] <= n_src[k] << 1;
        q_st[k] <= {q_src[k][Q_W-2:0], ge[k]};
        s_st[k] <= s_src[k];
      end
    end
  end

  assign out_valid = vld[Q_W-1];
  assign quo       = q_st[Q_W-1];
  assign rmd       = r_st[Q_W-1];
  assign side_out  = s_st[Q_W-1];

endmodule

`default_nettype wire

// ===== hw/rtl/pft_cfg.sv =====
// Configuration register file for the foot trajectory core.
// Depends on pft_pkg for the register codes and the cfg_t bundle.
`default_nettype none

module pft_cfg
  import pft_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_idx,
  input  logic [31:0] cfg_wdata,
  output cfg_t        cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_x         <= '0;
      cfg.start_z         <= '0;
      cfg.stride          <= '0;
      cfg.lift            <= '0;
      cfg.start_time      <= '0;
      cfg.swing_ticks     <= SWING_RST;
      cfg.stance_ticks    <= STANCE_RST;
      cfg.half_first_step <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_idx))
        REG_START_X:      cfg.start_x         <= $signed(cfg_wdata);
        REG_START_Z:      cfg.start_z         <= $signed(cfg_wdata);
        REG_STEP_LENGTH:  cfg.stride          <= $signed(cfg_wdata);
        REG_STEP_HEIGHT:  cfg.lift            <= $signed(cfg_wdata);
        REG_START_TIME:   cfg.start_time      <= cfg_wdata;
        REG_SWING_TICKS:  cfg.swing_ticks     <= cfg_wdata[TICK_W-1:0];
        REG_STANCE_TICKS: cfg.stance_ticks    <= cfg_wdata[TICK_W-1:0];
        REG_HALF_FIRST:   cfg.half_first_step <= cfg_wdata[0];
      endcase
    end
  end

endmodule

`default_nettype wire
